### design/pksw_pkg.sv
// Shared constants and field widths for the per-key sliding window rate limiter.
`timescale 1ns / 1ps

package pksw_pkg;

    // Default sizing
    localparam int NUM_STATIONS_DEF = 64;
    localparam int MAX_WINDOW_DEF   = 64;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int STA_W    = 6;
    localparam int CNT_W    = 24;
    localparam int WLEN_W   = 7;
    localparam int BUD_W    = 32;
    localparam int TOT_W    = 31;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 40;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REJECT    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNLIMITED = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [BUD_W-1:0] BUDGET_MIN = {1'b1, {(BUD_W-1){1'b0}}};

endpackage

### design/per_key_sliding_window_rate_limiter_core.sv
// Top level: station table, window ring and the command sequencer.
// Check, report and set_limit pass through states RD, EXEC and OUT, then the result is loaded into the output register.
// One item in work at a time: the input is not taken again until the result has been loaded;
// the input waits while the output register holds a result that was not taken.
// Tick walks every station through states RD, EXEC and TWR (record read, ring read, write back).
// Reset: synchronous active low, then the ST_CLR state clears the station table (no items).
`timescale 1ns / 1ps

module per_key_sliding_window_rate_limiter_core
    import pksw_pkg::*;
#(
    parameter int NUM_STATIONS = NUM_STATIONS_DEF,
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // station[5:0], amount[29:6], window_len[36:30], max_flow[60:37], zero fill
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]  i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // allowed[0], remaining[32:1], status[34:33], zero fill
    output logic [OUT_W-1:0]  o_m_axis_tdata
);

    localparam int SW    = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
    localparam int LW    = $clog2(MAX_WINDOW + 1);
    localparam int PW    = $clog2(MAX_WINDOW);
    localparam int RDEP  = NUM_STATIONS * MAX_WINDOW;
    localparam int RAW   = $clog2(RDEP);
    localparam int RW    = CNT_W + 1;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_EXEC = 3'd3;
    localparam logic [2:0] ST_TWR  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    typedef struct packed {
        logic             lv;
        logic [LW-1:0]    len;
        logic [CNT_W-1:0] flow;
        logic [PW-1:0]    pos;
        logic             wrap;
        logic [TOT_W-1:0] total;
        logic [CNT_W-1:0] loc;
        logic [CNT_W-1:0] rem;
        logic [BUD_W-1:0] bud;
        logic             bv;
    } t_rec;

    typedef struct packed {
        logic              allowed;
        logic [BUD_W-1:0]  remaining;
        logic [STAT_W-1:0] status;
    } t_res;

    logic [2:0]         r_state, n_state;
    logic [SW-1:0]      r_sta, n_sta;
    logic               r_en;
    logic [CMD_W-1:0]   r_cmd;
    logic               r_inr;
    logic [CNT_W-1:0]   r_amt;
    logic [WLEN_W-1:0]  r_wlen;
    logic [CNT_W-1:0]   r_mflow;
    t_res               r_res, n_res;
    logic               r_ov;
    logic [OUT_W-1:0]   r_odata;

    t_rec               rec_rd, rec_wd;
    logic               rec_we;
    logic [RW-1:0]      ring_rd;
    logic               ring_we;
    logic [RAW-1:0]     ring_raddr, ring_waddr, ring_base;
    logic [RW-1:0]      fresh;

    logic               in_xfer, out_xfer, out_load;
    logic [5:0]         in_sta;
    logic               last_sta;

    // Input and output transfers
    assign in_sta          = i_s_axis_tdata[5:0];
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer        = r_ov && i_m_axis_tready;
    assign out_load        = (r_state == ST_OUT) && (!r_ov || i_m_axis_tready);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;
    assign last_sta        = (r_sta == SW'(NUM_STATIONS - 1));

    pksw_ram #(.DATA_W($bits(t_rec)), .DEPTH(NUM_STATIONS), .ADDR_W(SW)) u_sta_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (r_sta),
        .i_wdata (rec_wd),
        .i_raddr (r_sta),
        .o_rdata (rec_rd)
    );

    pksw_ram #(.DATA_W(RW), .DEPTH(RDEP), .ADDR_W(RAW)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (fresh),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rd)
    );

    // Sequencer and record update
    always_comb begin
        logic [LW-1:0]    idx_ext;
        logic [PW-1:0]    nxt;
        logic [RW-1:0]    old;
        logic [TOT_W:0]   tot_sum;
        logic [BUD_W-1:0] diff;
        logic [BUD_W:0]   b33;
        logic [RW-1:0]    rsum;
        logic             deny;
        logic             bud_v;

        n_state    = r_state;
        n_sta      = r_sta;
        n_res      = r_res;
        rec_we     = 1'b0;
        rec_wd     = rec_rd;
        ring_we    = 1'b0;

        ring_base  = RAW'(r_sta) * RAW'(MAX_WINDOW);
        idx_ext    = LW'(rec_rd.pos);
        nxt        = ((idx_ext + LW'(1)) == rec_rd.len) ? '0 : rec_rd.pos + PW'(1);
        ring_raddr = ring_base + RAW'(nxt);
        ring_waddr = ring_base + RAW'(rec_rd.pos);
        fresh      = RW'(rec_rd.loc) + RW'(rec_rd.rem);

        // Ring slot that drops out of the window
        if (nxt == rec_rd.pos) begin
            old = fresh;
        end else if (rec_rd.wrap || nxt == '0) begin
            old = ring_rd;
        end else begin
            old = '0;
        end
        tot_sum = {1'b0, rec_rd.total} + (TOT_W + 1)'(fresh) - (TOT_W + 1)'(old);
        diff    = BUD_W'(rec_rd.flow) - BUD_W'(tot_sum[TOT_W-1:0]);

        deny  = $signed({9'b0, rec_rd.loc}) >= $signed({rec_rd.bud[BUD_W-1], rec_rd.bud});
        b33   = (rec_rd.bv ? {rec_rd.bud[BUD_W-1], rec_rd.bud} : '0)
                - (BUD_W + 1)'(r_amt);
        rsum  = RW'(rec_rd.rem) + RW'(r_amt);
        bud_v = rec_rd.bv;

        unique case (r_state)
            ST_CLR: begin
                rec_we = 1'b1;
                rec_wd = '0;
                n_sta  = r_sta + SW'(1);
                if (last_sta) begin
                    n_sta   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_sta   = (i_s_axis_tuser == CMD_TICK) ? '0 : SW'(in_sta);
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_res.allowed   = 1'b1;
                n_res.status    = STAT_OK;
                n_res.remaining = '0;
                n_state         = ST_OUT;
                case (r_cmd)
                    CMD_CHECK: begin
                        if (!r_en || !r_inr || !rec_rd.bv) begin
                            n_res.status = STAT_UNLIMITED;
                        end else if (deny) begin
                            n_res.allowed = 1'b0;
                        end else if (rec_rd.loc != CNT_MAX) begin
                            rec_we     = 1'b1;
                            rec_wd.loc = rec_rd.loc + CNT_W'(1);
                        end
                        if (r_inr && rec_rd.bv) begin
                            n_res.remaining = rec_rd.bud;
                        end
                    end
                    CMD_REPORT: begin
                        if (r_inr && rec_rd.lv) begin
                            rec_we     = 1'b1;
                            rec_wd.bv  = 1'b1;
                            rec_wd.bud = (b33[BUD_W] && !b33[BUD_W-1]) ? BUDGET_MIN
                                                                      : b33[BUD_W-1:0];
                            rec_wd.rem = rsum[CNT_W] ? CNT_MAX : rsum[CNT_W-1:0];
                            bud_v      = 1'b1;
                        end
                        if (!r_en || !r_inr || !bud_v) begin
                            n_res.status = STAT_UNLIMITED;
                        end
                        if (r_inr && bud_v) begin
                            n_res.remaining = rec_wd.bud;
                        end
                    end
                    CMD_TICK: begin
                        n_state = ST_TWR;
                    end
                    default: begin
                        if (!r_inr || r_wlen == '0 || 32'(r_wlen) > MAX_WINDOW
                            || r_mflow == '0) begin
                            n_res.status = STAT_REJECT;
                        end else begin
                            rec_we       = 1'b1;
                            rec_wd.lv    = 1'b1;
                            rec_wd.len   = LW'(r_wlen);
                            rec_wd.flow  = r_mflow;
                            rec_wd.pos   = '0;
                            rec_wd.wrap  = 1'b0;
                            rec_wd.total = '0;
                        end
                        if (r_inr && rec_rd.bv) begin
                            n_res.remaining = rec_rd.bud;
                        end
                    end
                endcase
            end
            ST_TWR: begin
                rec_we     = 1'b1;
                rec_wd.loc = '0;
                rec_wd.rem = '0;
                if (rec_rd.lv) begin
                    ring_we      = 1'b1;
                    rec_wd.total = tot_sum[TOT_W-1:0];
                    rec_wd.bud   = diff[BUD_W-1] ? '0 : diff;
                    rec_wd.bv    = 1'b1;
                    rec_wd.pos   = nxt;
                    rec_wd.wrap  = rec_rd.wrap || (nxt == '0);
                end else begin
                    rec_wd.bv  = 1'b0;
                    rec_wd.bud = '0;
                end
                if (last_sta) begin
                    n_state = ST_OUT;
                end else begin
                    n_sta   = r_sta + SW'(1);
                    n_state = ST_RD;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_sta   <= '0;
            r_en    <= 1'b1;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sta   <= n_sta;
            if (i_cfg_wr_en) begin
                r_en <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (out_xfer) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (in_xfer) begin
            r_cmd   <= i_s_axis_tuser;
            r_inr   <= (32'(in_sta) < NUM_STATIONS);
            r_amt   <= i_s_axis_tdata[29:6];
            r_wlen  <= i_s_axis_tdata[36:30];
            r_mflow <= i_s_axis_tdata[60:37];
        end
        if (out_load) begin
            r_odata <= {5'b0, r_res.status, r_res.remaining, r_res.allowed};
        end
    end

`ifndef SYNTHESIS
    // One item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_s_axis_tready)
        else $error("input taken while an item is in work");

    // A loaded result shows up as valid
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_m_axis_tvalid)
        else $error("result load lost");

    // Ring is written only during the tick walk
    a_ring_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_we |-> (r_state == ST_TWR) && (r_cmd == CMD_TICK))
        else $error("ring write outside tick");
`endif

endmodule

### design/pksw_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps

module pksw_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### tb/testbench.sv
// Self-checking testbench for the per-station sliding window rate limiter core.
`timescale 1ns / 1ps

module testbench;
    import pksw_pkg::*;

    localparam int NST  = 64;
    localparam int MAXW = 64;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [STA_W-1:0]  station;
        logic [CNT_W-1:0]  amount;
        logic [WLEN_W-1:0] wlen;
        logic [CNT_W-1:0]  mflow;
    } t_limiter_req;

    typedef struct packed {
        logic              allowed;
        logic [BUD_W-1:0]  remaining;
        logic [STAT_W-1:0] status;
    } t_limiter_rsp;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic              i_cfg_wr_data;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata;
    logic [CMD_W-1:0]  i_s_axis_tuser;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [OUT_W-1:0]  o_m_axis_tdata;

    per_key_sliding_window_rate_limiter_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    // Predictor state
    logic              enable_m;
    logic              lim_ok   [NST];
    int unsigned       win_len  [NST];
    longint            flow_lim [NST];
    longint            ring     [NST][MAXW];
    int unsigned       ring_pos [NST];
    longint            win_sum  [NST];
    longint            local_cnt[NST];
    longint            remote_cnt[NST];
    longint            budget   [NST];
    logic              budget_ok[NST];

    t_limiter_req pending_reqs[$];
    t_limiter_rsp expected_rsps[$];
    int  mismatches;
    int  accepted;
    bit  hold_sender;
    bit  rx_hold_req;
    bit  rx_hold;

    function automatic logic [BUD_W-1:0] budget_word(int s);
        return budget_ok[s] ? BUD_W'(budget[s]) : '0;
    endfunction

    // Advance every station's window by one tick
    function automatic void tick_stations();
        int unsigned len, idx, nxt;
        longint fresh, rem;
        for (int s = 0; s < NST; s++) begin
            if (lim_ok[s]) begin
                len = win_len[s];
                if (len == 0 || len > MAXW) len = 1;
                idx = ring_pos[s] % len;
                nxt = (idx + 1) % len;
                fresh = local_cnt[s] + remote_cnt[s];
                ring[s][idx] = fresh;
                win_sum[s] = win_sum[s] + fresh - ring[s][nxt];
                rem = flow_lim[s] - win_sum[s];
                budget[s] = rem > 0 ? rem : 0;
                budget_ok[s] = 1;
                ring_pos[s] = nxt;
            end else begin
                budget_ok[s] = 0;
                budget[s] = 0;
            end
            local_cnt[s] = 0;
            remote_cnt[s] = 0;
        end
    endfunction

    function automatic t_limiter_rsp predict_verdict(t_limiter_req r);
        t_limiter_rsp o;
        int s;
        longint b;
        s = r.station;
        o.allowed = 1'b1;
        o.remaining = '0;
        o.status = STAT_OK;
        case (r.cmd)
            CMD_CHECK: begin
                if (!enable_m || !budget_ok[s]) begin
                    o.status = STAT_UNLIMITED;
                end else if (local_cnt[s] >= budget[s]) begin
                    o.allowed = 1'b0;
                end else if (local_cnt[s] < CNT_MAX) begin
                    local_cnt[s]++;
                end
                o.remaining = budget_word(s);
            end
            CMD_REPORT: begin
                if (lim_ok[s]) begin
                    b = budget_ok[s] ? budget[s] : 0;
                    b -= r.amount;
                    budget[s] = b < -64'sd2147483648 ? -64'sd2147483648 : b;
                    budget_ok[s] = 1;
                    remote_cnt[s] += r.amount;
                    if (remote_cnt[s] > CNT_MAX) remote_cnt[s] = CNT_MAX;
                end
                if (!enable_m || !budget_ok[s]) o.status = STAT_UNLIMITED;
                o.remaining = budget_word(s);
            end
            CMD_TICK: tick_stations();
            default: begin
                if (r.wlen == 0 || r.wlen > MAXW || r.mflow == 0) begin
                    o.status = STAT_REJECT;
                end else begin
                    lim_ok[s] = 1;
                    win_len[s] = r.wlen;
                    flow_lim[s] = r.mflow;
                    for (int i = 0; i < MAXW; i++) ring[s][i] = 0;
                    ring_pos[s] = 0;
                    win_sum[s] = 0;
                end
                o.remaining = budget_word(s);
            end
        endcase
        return o;
    endfunction

    function automatic t_limiter_req make_req(logic [1:0] c, int s, int a, int w, int f);
        t_limiter_req r;
        r.cmd = c;
        r.station = STA_W'(s);
        r.amount = CNT_W'(a);
        r.wlen = WLEN_W'(w);
        r.mflow = CNT_W'(f);
        return r;
    endfunction

    // Weighted random item: mostly checks on a few busy stations
    function automatic t_limiter_req rand_req();
        int k, s, f;
        k = $urandom_range(0, 99);
        s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
        f = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 12);
        if (k < 55) return make_req(CMD_CHECK, s, $urandom, $urandom, $urandom);
        if (k < 70) return make_req(CMD_REPORT, s,
                        ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4),
                        $urandom, $urandom);
        if (k < 85) return make_req(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
        return make_req(CMD_SET, s, $urandom,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(1, 6), f);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Clock
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Timeout
    initial begin
        #50ms;
        $display("per_key_sliding_window_rate_limiter_core test failed");
        $finish;
    end

    // Sample handshake at the rising edge
    logic o_s_axis_tready_q;
    always @(posedge i_clk) o_s_axis_tready_q <= i_rst_n && o_s_axis_tready;

    // Driver: offers queued items at the falling edge
    int  tx_gap;
    initial begin
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        tx_gap = 0;
    end
    always @(negedge i_clk) begin
        t_limiter_req r;
        if (i_s_axis_tvalid && o_s_axis_tready_q) begin
            accepted++;
            tx_gap = gap_len();
        end
        if (i_s_axis_tvalid && !o_s_axis_tready_q) begin
            // keep offering
        end else if (tx_gap > 0 || hold_sender || pending_reqs.size() == 0) begin
            if (tx_gap > 0) tx_gap--;
            i_s_axis_tvalid <= 1'b0;
        end else begin
            r = pending_reqs.pop_front();
            expected_rsps.push_back(predict_verdict(r));
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tuser <= r.cmd;
            i_s_axis_tdata <= {3'b0, r.mflow, r.wlen, r.amount, r.station};
        end
    end

    // Receiver stalls
    int rx_gap;
    int rx_long;
    initial begin
        i_m_axis_tready = 0;
        rx_gap = 0;
        rx_long = 0;
    end
    always @(negedge i_clk) begin
        if (rx_hold_req && rx_long == 0 && !rx_hold) begin
            rx_hold <= 1;
            rx_long = 400;
        end
        if (rx_long > 0) begin
            rx_long--;
            if (rx_long == 0) rx_hold <= 0;
            i_m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            rx_gap = gap_len();
            i_m_axis_tready <= 1'b1;
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_limiter_rsp got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.allowed = o_m_axis_tdata[0];
            got.remaining = o_m_axis_tdata[32:1];
            got.status = o_m_axis_tdata[34:33];
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_m_axis_tdata);
            end else begin
                want = expected_rsps.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp allowed %0b rem %0d st %0d, got %0b %0d %0d",
                                 want.allowed, $signed(want.remaining), want.status,
                                 got.allowed, $signed(got.remaining), got.status);
                end
            end
        end
    end

    task automatic write_enable(logic v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        enable_m = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Wait until the queue and the block have drained
    task automatic drain();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        repeat (3 * NST + 10) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
        drain();
    endtask

    // Stimulus
    initial begin
        mismatches = 0;
        accepted = 0;
        hold_sender = 0;
        rx_hold_req = 0;
        rx_hold = 0;
        enable_m = 1;
        i_cfg_wr_en = 0;
        i_cfg_wr_data = 0;
        for (int s = 0; s < NST; s++) begin
            lim_ok[s] = 0; win_len[s] = 0; flow_lim[s] = 0; ring_pos[s] = 0;
            win_sum[s] = 0; local_cnt[s] = 0; remote_cnt[s] = 0; budget[s] = 0;
            budget_ok[s] = 0;
            for (int i = 0; i < MAXW; i++) ring[s][i] = 0;
        end
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: unconfigured, rejects, extremes, window of one, saturation
        pending_reqs.push_back(make_req(CMD_CHECK, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_REPORT, 1, 5, 0, 0));
        pending_reqs.push_back(make_req(CMD_SET, 2, 0, 0, 10));
        pending_reqs.push_back(make_req(CMD_SET, 2, 0, 65, 10));
        pending_reqs.push_back(make_req(CMD_SET, 2, 0, 127, 10));
        pending_reqs.push_back(make_req(CMD_SET, 2, 0, 3, 0));
        pending_reqs.push_back(make_req(CMD_SET, 63, 0, 64, 'hFFFFFF));
        pending_reqs.push_back(make_req(CMD_SET, 1, 0, 1, 2));
        pending_reqs.push_back(make_req(CMD_SET, 0, 0, 2, 3));
        pending_reqs.push_back(make_req(CMD_REPORT, 0, 1, 0, 0));
        pending_reqs.push_back(make_req(CMD_CHECK, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_TICK, 63, 'hFFFFFF, 127, 'hFFFFFF));
        for (int i = 0; i < 4; i++) pending_reqs.push_back(make_req(CMD_CHECK, 1, 0, 0, 0));
        for (int i = 0; i < 4; i++) pending_reqs.push_back(make_req(CMD_CHECK, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_TICK, 0, 0, 0, 0));
        for (int i = 0; i < 3; i++)
            pending_reqs.push_back(make_req(CMD_REPORT, 63, 'hFFFFFF, 0, 0));
        pending_reqs.push_back(make_req(CMD_CHECK, 63, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_TICK, 0, 0, 0, 0));
        drain();
        // Drive the budget toward its negative floor
        for (int i = 0; i < 140; i++)
            pending_reqs.push_back(make_req(CMD_REPORT, 63, 'hFFFFFF, 0, 0));
        drain();

        random_phase(500);
        write_enable(1'b0);
        random_phase(250);

        // Receiver holds off while the sender keeps offering
        rx_hold_req = 1;
        for (int i = 0; i < 40; i++) pending_reqs.push_back(rand_req());
        while (!rx_hold) @(posedge i_clk);
        rx_hold_req = 0;
        drain();
        write_enable(1'b1);

        // Sender pauses until all results are in
        for (int i = 0; i < 30; i++) pending_reqs.push_back(rand_req());
        while (pending_reqs.size() != 0) @(posedge i_clk);
        hold_sender = 1;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        hold_sender = 0;
        random_phase(560);

        if (expected_rsps.size() != 0) mismatches++;
        if (mismatches == 0)
            $display("per_key_sliding_window_rate_limiter_core test passed");
        else
            $display("per_key_sliding_window_rate_limiter_core test failed");
        $finish;
    end

endmodule
